// ----- rtl/lzss_window_decompressor_assert.svh -----
// Assertion macros shared by the LZSS window decompressor RTL.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef LZSS_WINDOW_DECOMPRESSOR_ASSERT_SVH
`define LZSS_WINDOW_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LZSSWD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lzsswd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LZSSWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lzsswd assertion failed");

`endif

// ----- rtl/lzsswd_pkg.sv -----
// Shared types and constants of the LZSS window decompressor.
// Depends on nothing; used by the front end, command queue, back end and top level.
`default_nettype none

package lzsswd_pkg;

	localparam int CFG_ADDR_W = 3;
	localparam logic REG_OUT_LENGTH = 1'b0;
	localparam logic [31:0] OUT_LENGTH_RESET = 32'd1;

	localparam logic [4:0] MATCH_BIAS = 5'd3;
	localparam logic [8:0] FLAG_MARKER = 9'h100;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;

	typedef struct packed {
		logic is_match;
		logic [7:0] data;
		logic [3:0] off_hi;
		logic [4:0] count;
		logic status;
		logic done;
		logic final_b;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/lzsswd_if.sv -----
// Valid/ready channel interfaces for compressed input and decompressed results.
// Depends on nothing.
`default_nettype none

interface lzsswd_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;
	logic final_byte;

	modport source (output valid, output in_byte, output final_byte, input ready);
	modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

interface lzsswd_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic data_valid;
	logic run_end;
	logic complete;
	logic truncated;

	modport source (output valid, output out_byte, output data_valid, output run_end,
		output complete, output truncated, input ready);
	modport sink (input valid, input out_byte, input data_valid, input run_end,
		input complete, input truncated, output ready);
endinterface

`default_nettype wire

// ----- rtl/lzsswd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module lzsswd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lzsswd_front.sv -----
// Front end: accepts compressed bytes, tracks token parsing and the output count,
// and issues one command per item. Depends on lzsswd_pkg and lzsswd_if.
`default_nettype none

module lzsswd_front (
	input wire logic clk,
	input wire logic arst_n,
	lzsswd_in_if.sink in_ch,
	input wire logic [31:0] out_length,
	input wire lzsswd_pkg::q_stat_t q_stat,
	output logic push,
	output lzsswd_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		PH_BOUNDARY = 2'd0,
		PH_FIRST = 2'd1,
		PH_SECOND = 2'd2
	} phase_t;

	phase_t phase_q, phase_n;
	logic [8:0] flags_q, flags_n;
	logic [7:0] match_lo_q, match_lo_n;
	logic [31:0] emitted_q;

	logic accept;
	logic done_now;
	logic [31:0] remaining;
	logic [8:0] shifted;
	logic [4:0] match_len;
	logic len_covers;
	logic take_first;
	logic first_lit;
	logic [4:0] n;
	logic done;
	logic is_match;

	assign in_ch.ready = !q_stat.full;
	assign accept = in_ch.valid && in_ch.ready;

	assign done_now = emitted_q >= out_length;
	assign remaining = out_length - emitted_q;
	assign shifted = {1'b0, flags_q[8:1]};
	assign match_len = {1'b0, in_ch.in_byte[3:0]} + lzsswd_pkg::MATCH_BIAS;
	assign len_covers = {27'd0, match_len} >= remaining;

	always_comb begin
		phase_n = phase_q;
		flags_n = flags_q;
		match_lo_n = match_lo_q;
		n = 5'd0;
		done = done_now;
		is_match = 1'b0;
		take_first = 1'b0;
		first_lit = 1'b0;
		if (!done_now) begin
			case (phase_q)
				PH_FIRST: begin
					take_first = 1'b1;
					first_lit = flags_q[0];
				end
				PH_SECOND: begin
					is_match = 1'b1;
					n = len_covers ? remaining[4:0] : match_len;
					done = len_covers;
					phase_n = PH_BOUNDARY;
				end
				default: begin
					flags_n = shifted;
					if (shifted[8:1] == 8'd0) begin
						flags_n = lzsswd_pkg::FLAG_MARKER | {1'b0, in_ch.in_byte};
						phase_n = PH_FIRST;
					end else begin
						take_first = 1'b1;
						first_lit = shifted[0];
					end
				end
			endcase
			if (take_first) begin
				if (first_lit) begin
					n = 5'd1;
					done = remaining == 32'd1;
					phase_n = PH_BOUNDARY;
				end else begin
					match_lo_n = in_ch.in_byte;
					phase_n = PH_SECOND;
				end
			end
		end
	end

	assign push = accept;
	assign cmd.is_match = is_match;
	assign cmd.data = is_match ? match_lo_q : in_ch.in_byte;
	assign cmd.off_hi = in_ch.in_byte[7:4];
	assign cmd.count = n;
	assign cmd.status = in_ch.final_byte || (n == 5'd0);
	assign cmd.done = done;
	assign cmd.final_b = in_ch.final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BOUNDARY;
			flags_q <= 9'd0;
			match_lo_q <= 8'd0;
			emitted_q <= 32'd0;
		end else if (accept) begin
			phase_q <= phase_n;
			flags_q <= flags_n;
			match_lo_q <= match_lo_n;
			emitted_q <= emitted_q + {27'd0, n};
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lzsswd_cmd_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on lzsswd_pkg.
`default_nettype none

module lzsswd_cmd_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire lzsswd_pkg::cmd_t cmd_in,
	input wire logic pop,
	output lzsswd_pkg::cmd_t cmd_out,
	output lzsswd_pkg::q_stat_t q_stat
);

	lzsswd_pkg::cmd_t entries_q [lzsswd_pkg::QUEUE_DEPTH];
	logic [lzsswd_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [lzsswd_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [lzsswd_pkg::QPTR_W:0] count_q;

	assign q_stat.full = count_q == (lzsswd_pkg::QPTR_W + 1)'(lzsswd_pkg::QUEUE_DEPTH);
	assign q_stat.empty = count_q == '0;
	assign cmd_out = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lzsswd_back.sv -----
// Back end: expands commands into result items, copies from the history window
// and drives the output register. Depends on lzsswd_pkg, lzsswd_if and lzsswd_ram.
`default_nettype none

module lzsswd_back #(
	parameter int WINDOW_BYTES = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire lzsswd_pkg::cmd_t cmd,
	input wire lzsswd_pkg::q_stat_t q_stat,
	output logic pop,
	lzsswd_out_if.source out_ch
);

	localparam int AW = $clog2(WINDOW_BYTES);
	localparam logic [AW-1:0] WIN_START = AW'(12'hFEE);
	localparam logic [AW:0] FILL_FULL = (AW + 1)'(WINDOW_BYTES);

	logic active_q;
	logic is_match_q;
	logic [7:0] lit_q;
	logic [4:0] rem_q;
	logic [AW-1:0] addr_q;
	logic status_q;
	logic done_q;
	logic final_q;

	logic [AW-1:0] wpos_q;
	logic [AW:0] fill_q;

	logic valid_s1;
	logic ram_s1;
	logic [7:0] byte_s1;
	logic fwd_s1;
	logic ok_s1;
	logic dv_s1;
	logic run_end_s1;
	logic complete_s1;
	logic trunc_s1;

	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic dv_q;
	logic run_end_q;
	logic complete_q;
	logic trunc_q;

	logic [7:0] rdata;
	logic [7:0] s1_value;
	logic s1_move;
	logic s1_free;
	logic gen;
	logic gen_data;
	logic last_data;
	logic re;
	logic we;
	logic [AW-1:0] rel;
	logic ok;
	logic fwd;

	lzsswd_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_BYTES)
	) u_window (
		.clk(clk),
		.we(we),
		.waddr(wpos_q),
		.wdata(s1_value),
		.re(re),
		.raddr(addr_q),
		.rdata(rdata)
	);

	// Entries never written since reset read as zero; the window fills in order from
	// the start position, so a fill count tells which entries hold data.
	assign s1_value = ram_s1 ? (fwd_s1 ? byte_s1 : (ok_s1 ? rdata : 8'h00)) : byte_s1;
	assign s1_move = valid_s1 && (!out_valid_q || out_ch.ready);
	assign s1_free = !valid_s1 || s1_move;
	assign gen = active_q && s1_free;
	assign gen_data = gen && (rem_q != 5'd0);
	assign last_data = rem_q == 5'd1;
	assign re = gen_data && is_match_q;
	assign we = s1_move && dv_s1;
	assign rel = addr_q - WIN_START;
	assign ok = {1'b0, rel} < fill_q;
	assign fwd = we && (addr_q == wpos_q);
	assign pop = !active_q && !q_stat.empty;

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.data_valid = dv_q;
	assign out_ch.run_end = run_end_q;
	assign out_ch.complete = complete_q;
	assign out_ch.truncated = trunc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			wpos_q <= WIN_START;
			fill_q <= '0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
			end else if (gen) begin
				if (!gen_data || (last_data && !status_q)) begin
					active_q <= 1'b0;
				end
			end
			if (gen) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (we) begin
				wpos_q <= wpos_q + 1'b1;
				if (fill_q != FILL_FULL) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			is_match_q <= cmd.is_match;
			lit_q <= cmd.data;
			rem_q <= cmd.count;
			addr_q <= AW'({cmd.off_hi, cmd.data});
			status_q <= cmd.status;
			done_q <= cmd.done;
			final_q <= cmd.final_b;
		end else if (gen_data) begin
			rem_q <= rem_q - 1'b1;
			addr_q <= addr_q + 1'b1;
		end
		if (gen) begin
			ram_s1 <= gen_data && is_match_q;
			byte_s1 <= !gen_data ? 8'h00 : (is_match_q ? s1_value : lit_q);
			fwd_s1 <= fwd;
			ok_s1 <= ok;
			dv_s1 <= gen_data;
			run_end_s1 <= !gen_data || (last_data && !status_q);
			complete_s1 <= gen_data ? (last_data && done_q) : done_q;
			trunc_s1 <= !gen_data && final_q && !done_q;
		end
		if (s1_move) begin
			out_byte_q <= s1_value;
			dv_q <= dv_s1;
			run_end_q <= run_end_s1;
			complete_q <= complete_s1;
			trunc_q <= trunc_s1;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lzss_window_decompressor.sv -----
// Top level of the LZSS window decompressor: configuration port, front end,
// command queue and back end. Depends on lzsswd_pkg, lzsswd_if and all submodules.
//
// Compressed payload bytes enter on in_ch, one item per byte, with final_byte
// marking the last byte of a stream. Each input item yields one to nineteen
// result items on out_ch: the decompressed bytes, then a status item when the
// input was a final byte or produced no data. run_end marks the last result of
// an input item. The register out_length (APB, address 0) sets the stream size
// and must be written only while the block is idle; this is not enforced.
// The front end takes one input item per cycle while its four-entry command
// queue has room. The back end loads a command, then emits its result items as
// the output register frees, and takes the next command only when done; a match
// of 18 bytes followed by a status item is the longest. Results pass from the
// queue through the command registers, a stage and the output register.
// Reset empties the queue and restarts the stream; the history window reads as
// zero from reset on through a fill count, with no clearing pass. When the
// receiver stalls, results wait in an output register and one stage behind it,
// the queue fills, and in_ch then deasserts ready.
`default_nettype none

`include "lzss_window_decompressor_assert.svh"

module lzss_window_decompressor #(
	parameter int WINDOW_BYTES = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	lzsswd_in_if.sink in_ch,
	lzsswd_out_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [lzsswd_pkg::CFG_ADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [31:0] out_length_q;
	logic cfg_write;
	logic reg_sel;

	logic push;
	logic pop;
	lzsswd_pkg::cmd_t front_cmd;
	lzsswd_pkg::cmd_t back_cmd;
	lzsswd_pkg::q_stat_t q_stat;

	assign pready = 1'b1;
	assign reg_sel = paddr[lzsswd_pkg::CFG_ADDR_W-1];
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata = (reg_sel == lzsswd_pkg::REG_OUT_LENGTH) ? out_length_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_length_q <= lzsswd_pkg::OUT_LENGTH_RESET;
		end else if (cfg_write && (reg_sel == lzsswd_pkg::REG_OUT_LENGTH)) begin
			out_length_q <= pwdata;
		end
	end

	lzsswd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_length(out_length_q),
		.q_stat(q_stat),
		.push(push),
		.cmd(front_cmd)
	);

	lzsswd_cmd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.cmd_in(front_cmd),
		.pop(pop),
		.cmd_out(back_cmd),
		.q_stat(q_stat)
	);

	lzsswd_back #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(back_cmd),
		.q_stat(q_stat),
		.pop(pop),
		.out_ch(out_ch)
	);

	`LZSSWD_ASSERT_IMP(a_status_byte_zero, clk, arst_n, out_ch.valid && !out_ch.data_valid, out_ch.out_byte == 8'h00)
	`LZSSWD_ASSERT_IMP(a_trunc_is_last, clk, arst_n, out_ch.valid && out_ch.truncated, out_ch.run_end && !out_ch.complete)
	`LZSSWD_ASSERT_NEXT(a_out_held, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
	`LZSSWD_ASSERT_NEXT(a_push_fills_queue, clk, arst_n, push && !pop, !q_stat.empty)

endmodule

`default_nettype wire

// ----- tb/sv/lzss_window_decompressor_test.sv -----
// Self-checking testbench for the LZSS window decompressor.
// Depends on lzsswd_pkg, the lzsswd_in_if/lzsswd_out_if channel interfaces and the block itself.
// A scoreboard class predicts every result item from the accepted input items.
module lzss_window_decompressor_test;
	import lzsswd_pkg::*;

	localparam int WINDOW_SIZE = 4096;
	localparam logic [11:0] WINDOW_START = 12'hFEE;
	localparam logic [CFG_ADDR_W-1:0] OUT_LENGTH_ADDR = CFG_ADDR_W'(4 * REG_OUT_LENGTH);
	localparam logic [31:0] LENGTH_MAX = 32'hFFFF_FFFF;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 25;
	localparam int QUIET_LIMIT = 4000;

	typedef enum logic [1:0] {
		AT_BOUNDARY,
		WANT_TOKEN,
		WANT_MATCH_HI
	} parse_state_e;

	typedef struct packed {
		logic [7:0] out_byte;
		logic data_valid;
		logic run_end;
		logic complete;
		logic truncated;
	} result_t;

	class decomp_scoreboard;
		logic [7:0] window [WINDOW_SIZE];
		logic [11:0] wpos;
		logic [8:0] flags;
		parse_state_e state;
		logic [7:0] match_lo;
		logic [31:0] emitted;
		logic [31:0] length;
		result_t expected_q[$];
		result_t held;
		bit held_valid;
		int step_bytes;
		int errors;

		function new();
			foreach (window[i]) window[i] = 8'h00;
			wpos = WINDOW_START;
			flags = '0;
			state = AT_BOUNDARY;
			match_lo = '0;
			emitted = '0;
			length = OUT_LENGTH_RESET;
			held_valid = 1'b0;
			step_bytes = 0;
			errors = 0;
		endfunction

		function bit reached();
			return emitted >= length;
		endfunction

		function bit at_flag_boundary();
			return state != WANT_TOKEN && state != WANT_MATCH_HI && (flags >> 1) <= 9'd1;
		endfunction

		// The last result of an item is held back so that run_end can be set on it.
		function void stage(result_t r);
			if (held_valid)
				expected_q.push_back(held);
			held = r;
			held_valid = 1'b1;
		endfunction

		function void put_byte(logic [7:0] c);
			result_t r;
			window[wpos] = c;
			wpos = wpos + 12'd1;
			emitted = emitted + 32'd1;
			r.out_byte = c;
			r.data_valid = 1'b1;
			r.run_end = 1'b0;
			r.complete = reached();
			r.truncated = 1'b0;
			stage(r);
			step_bytes++;
		endfunction

		function void token_start(logic [7:0] b);
			if (flags[0]) begin
				put_byte(b);
				state = AT_BOUNDARY;
			end else begin
				match_lo = b;
				state = WANT_MATCH_HI;
			end
		endfunction

		function void match_copy(logic [7:0] b);
			logic [11:0] src;
			int count;
			src = {b[7:4], match_lo};
			count = int'(b[3:0]) + int'(MATCH_BIAS);
			for (int j = 0; j < count && !reached(); j++) begin
				put_byte(window[src]);
				src = src + 12'd1;
			end
			state = AT_BOUNDARY;
		endfunction

		function void note(logic [7:0] b, logic fin);
			result_t r;
			step_bytes = 0;
			if (!reached()) begin
				case (state)
					WANT_TOKEN: token_start(b);
					WANT_MATCH_HI: match_copy(b);
					default: begin
						flags = flags >> 1;
						if (flags <= 9'd1) begin
							flags = FLAG_MARKER | {1'b0, b};
							state = WANT_TOKEN;
						end else begin
							token_start(b);
						end
					end
				endcase
			end
			if (fin || step_bytes == 0) begin
				r.out_byte = 8'h00;
				r.data_valid = 1'b0;
				r.run_end = 1'b0;
				r.complete = reached();
				r.truncated = fin && !reached();
				stage(r);
			end
			held.run_end = 1'b1;
			expected_q.push_back(held);
			held_valid = 1'b0;
		endfunction

		function void check(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result item: byte %02h valid %0b end %0b cpl %0b trn %0b",
						got.out_byte, got.data_valid, got.run_end, got.complete, got.truncated);
				return;
			end
			want = expected_q.pop_front();
			if (got.out_byte !== want.out_byte || got.data_valid !== want.data_valid ||
					got.run_end !== want.run_end || got.complete !== want.complete ||
					got.truncated !== want.truncated) begin
				errors++;
				if (errors <= 10)
					$display("result mismatch: expected byte %02h valid %0b end %0b cpl %0b trn %0b, got byte %02h valid %0b end %0b cpl %0b trn %0b",
						want.out_byte, want.data_valid, want.run_end, want.complete,
						want.truncated, got.out_byte, got.data_valid, got.run_end,
						got.complete, got.truncated);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	lzsswd_in_if in_ch ();
	lzsswd_out_if out_ch ();

	decomp_scoreboard sb = new();
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;
	int sent_items = 0;
	int reg_errors = 0;

	lzss_window_decompressor #(
		.WINDOW_BYTES(WINDOW_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin : monitor
		result_t got;
		quiet_cycles = quiet_cycles + 1;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.out_byte = out_ch.out_byte;
				got.data_valid = out_ch.data_valid;
				got.run_end = out_ch.run_end;
				got.complete = out_ch.complete;
				got.truncated = out_ch.truncated;
				sb.check(got);
				quiet_cycles = 0;
			end
			if (in_ch.valid && in_ch.ready) begin
				sb.note(in_ch.in_byte, in_ch.final_byte);
				quiet_cycles = 0;
			end
			if (psel && penable && pready)
				quiet_cycles = 0;
		end
	end

	initial begin : watchdog
		do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin : receiver
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ch.ready <= no_idle || ($urandom_range(99) >= 9);
		end
	end

	function automatic bit rare_final();
		return $urandom_range(99) < 2;
	endfunction

	task automatic send_item(logic [7:0] b, logic fin);
		while (!no_idle && $urandom_range(99) < 9) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.final_byte <= fin;
		do @(posedge clk); while (!in_ch.ready);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= OUT_LENGTH_ADDR;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.length = value;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			reg_errors++;
			$display("out_length read back %08h, wrote %08h", prdata, value);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// One flag byte and its eight tokens; about half the matches point just behind
	// the write position so that copies overlap the bytes they produce.
	task automatic send_group();
		logic [7:0] flag_bits;
		logic [11:0] src;
		logic [3:0] run;
		flag_bits = 8'($urandom);
		send_item(flag_bits, rare_final());
		for (int t = 0; t < 8; t++) begin
			if (flag_bits[t]) begin
				send_item(8'($urandom), rare_final());
			end else begin
				if ($urandom_range(1) == 1)
					src = sb.wpos - 12'($urandom_range(20, 1));
				else
					src = 12'($urandom);
				run = 4'($urandom);
				send_item(src[7:0], rare_final());
				send_item({src[11:8], run}, rare_final());
			end
		end
	endtask

	task automatic send_noise();
		repeat ($urandom_range(4, 1))
			send_item(8'($urandom), $urandom_range(9) == 0);
	endtask

	task automatic run_phase(bit relative, logic [31:0] amount, int target, bit hold, bit steady);
		int start;
		int tries;
		drain_results();
		reg_write(relative ? sb.emitted + amount : amount);
		no_idle = steady;
		hold_req = hold;
		start = sent_items;
		while (sent_items - start < target && !sb.reached()) begin
			if ($urandom_range(99) < 85) begin
				tries = 0;
				while (!sb.at_flag_boundary() && !sb.reached() && tries < 20) begin
					send_item(8'($urandom), 1'b0);
					tries++;
				end
				send_group();
			end else begin
				send_noise();
			end
		end
		if (sb.reached())
			send_noise();
		no_idle = 1'b0;
	endtask

	initial begin : stimulus
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.final_byte = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset length of one: a single literal completes the stream, later
		// input is ignored, and a final byte after completion is not truncated.
		send_item(8'h01, 1'b0);
		send_item(8'h5A, 1'b0);
		send_item(8'h33, 1'b0);
		send_item(8'h77, 1'b1);

		drain_results();
		reg_write(32'h0000_0000);
		send_item(8'h12, 1'b1);

		// Raising the length resumes the seven pending matches: a maximal
		// overlapping copy, a copy from the untouched window, a final byte
		// on each byte of a match, and a maximal copy with a status item.
		drain_results();
		reg_write(LENGTH_MAX);
		send_item(8'hEE, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h34, 1'b0);
		send_item(8'h50, 1'b1);
		send_item(8'h10, 1'b1);
		send_item(8'h0F, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hF0, 1'b0);
		send_item(8'hAB, 1'b0);
		send_item(8'hCD, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(8'h0F, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(8'h80, 1'b0);
		send_item(8'h7F, 1'b0);

		// A long match that is cut short by the length.
		drain_results();
		reg_write(sb.emitted + 32'd5);
		send_item(8'h00, 1'b0);
		send_item(8'h0F, 1'b0);
		send_item(8'h22, 1'b0);

		run_phase(1'b0, LENGTH_MAX, 70, 1'b0, 1'b0);
		run_phase(1'b1, 32'($urandom_range(300, 60)), 70, 1'b0, 1'b0);
		run_phase(1'b0, LENGTH_MAX, 70, 1'b1, 1'b0);
		run_phase(1'b0, 32'd1, 6, 1'b0, 1'b0);
		run_phase(1'b1, 32'($urandom_range(400, 100)), 70, 1'b0, 1'b0);
		run_phase(1'b0, LENGTH_MAX, 70, 1'b0, 1'b1);
		run_phase(1'b1, 32'($urandom_range(40, 3)), 60, 1'b0, 1'b0);

		in_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (sb.expected_q.size() != 0)
			$display("%0d result items never arrived", sb.expected_q.size());
		if (sb.errors == 0 && reg_errors == 0 && sb.expected_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
